@@ rtl/ami_pkg.sv @@
`default_nettype none

package ami_pkg;

    // Request codes carried on req_type.
    typedef enum logic [1:0] {
        REQ_STEP  = 2'd0,
        REQ_ADD   = 2'd1,
        REQ_SET   = 2'd2,
        REQ_PLACE = 2'd3
    } req_kind_t;

    // Configuration register indexes.
    localparam logic [2:0] CFG_BOUND_X_MIN = 3'd0;
    localparam logic [2:0] CFG_BOUND_Z_MIN = 3'd1;
    localparam logic [2:0] CFG_BOUND_X_MAX = 3'd2;
    localparam logic [2:0] CFG_BOUND_Z_MAX = 3'd3;
    localparam logic [2:0] CFG_GOAL_X      = 3'd4;
    localparam int         CFG_COUNT       = 7;

    // Axis numbering within a vector.
    localparam logic [1:0] AXIS_X = 2'd0;
    localparam logic [1:0] AXIS_Z = 2'd2;

    // Fixed-point constants (Q16.16, squares in Q32.32).
    localparam logic [63:0] ACC_CAP_SQ = 64'd107374182400;
    localparam logic [63:0] SQRT_BIT0  = 64'h4000_0000_0000_0000;
    localparam int          SQRT_ITERS = 32;
    localparam int          DIV_ITERS  = 19;

    // Micro-operations issued by the controller to the datapath.
    typedef enum logic [4:0] {
        DP_NOP,
        DP_LOAD,
        DP_NEAR_CLR,
        DP_NEAR_MUL,
        DP_ACCUM,
        DP_NEAR_DONE,
        DP_MUL_ACC,
        DP_VEL_UPD,
        DP_MUL_VEL,
        DP_POS_UPD,
        DP_SUM_SAT,
        DP_SQ_MUL,
        DP_ACC_FROM_S,
        DP_SQRT_INIT,
        DP_SQRT_ITER,
        DP_DIV_INIT,
        DP_DIV_ITER,
        DP_DIV_DONE,
        DP_SET_ACC,
        DP_SET_POS,
        DP_PUBLISH
    } dp_op_t;

    typedef struct packed {
        dp_op_t     op;
        logic [1:0] axis;
    } dp_cmd_t;

    typedef struct packed {
        req_kind_t kind;
        logic      near_now;
        logic      cap_now;
        logic      out_busy;
    } dp_stat_t;

    // Controller states.
    typedef enum logic [4:0] {
        ST_IDLE,
        ST_DISPATCH,
        ST_NR_CLR,
        ST_NR_MUL,
        ST_NR_ACC,
        ST_NR_DONE,
        ST_ST_MULA,
        ST_ST_VEL,
        ST_ST_MULV,
        ST_ST_POS,
        ST_AD_MUL,
        ST_AD_ACC,
        ST_AD_CHECK,
        ST_SQ_ITER,
        ST_DV_INIT,
        ST_DV_ITER,
        ST_DV_DONE,
        ST_PUBLISH
    } state_t;

endpackage

`default_nettype wire

@@ rtl/ami_ctrl.sv @@
`default_nettype none

module ami_ctrl (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire ami_pkg::dp_stat_t stat,
    output ami_pkg::dp_cmd_t       cmd
);

    localparam logic [1:0] AXIS_LAST = ami_pkg::AXIS_Z;
    localparam logic [4:0] SQ_LAST   = 5'(ami_pkg::SQRT_ITERS - 1);
    localparam logic [4:0] DV_LAST   = 5'(ami_pkg::DIV_ITERS - 1);

    ami_pkg::state_t state_reg, state_next;
    logic [1:0] axis_reg, axis_next;
    logic [4:0] cnt_reg, cnt_next;
    logic       post_reg, post_next;

    // State register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ami_pkg::ST_IDLE;
            axis_reg  <= 2'd0;
            cnt_reg   <= 5'd0;
            post_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            axis_reg  <= axis_next;
            cnt_reg   <= cnt_next;
            post_reg  <= post_next;
        end
    end

    // Next state and datapath commands.
    always_comb
    begin
        state_next = state_reg;
        axis_next  = axis_reg;
        cnt_next   = cnt_reg;
        post_next  = post_reg;
        cmd.op     = ami_pkg::DP_NOP;
        cmd.axis   = axis_reg;
        in_ready   = 1'b0;
        case (state_reg)
            ami_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.op     = ami_pkg::DP_LOAD;
                    post_next  = 1'b0;
                    state_next = ami_pkg::ST_DISPATCH;
                end
            end
            ami_pkg::ST_DISPATCH:
            begin
                case (stat.kind)
                    ami_pkg::REQ_STEP:
                    begin
                        state_next = ami_pkg::ST_NR_CLR;
                    end
                    ami_pkg::REQ_ADD:
                    begin
                        cmd.op     = ami_pkg::DP_SUM_SAT;
                        axis_next  = 2'd0;
                        state_next = ami_pkg::ST_AD_MUL;
                    end
                    ami_pkg::REQ_SET:
                    begin
                        cmd.op     = ami_pkg::DP_SET_ACC;
                        post_next  = 1'b1;
                        state_next = ami_pkg::ST_NR_CLR;
                    end
                    default:
                    begin
                        cmd.op     = ami_pkg::DP_SET_POS;
                        post_next  = 1'b1;
                        state_next = ami_pkg::ST_NR_CLR;
                    end
                endcase
            end
            ami_pkg::ST_NR_CLR:
            begin
                cmd.op     = ami_pkg::DP_NEAR_CLR;
                axis_next  = 2'd0;
                state_next = ami_pkg::ST_NR_MUL;
            end
            ami_pkg::ST_NR_MUL:
            begin
                cmd.op     = ami_pkg::DP_NEAR_MUL;
                state_next = ami_pkg::ST_NR_ACC;
            end
            ami_pkg::ST_NR_ACC:
            begin
                cmd.op = ami_pkg::DP_ACCUM;
                if (axis_reg == AXIS_LAST)
                begin
                    state_next = ami_pkg::ST_NR_DONE;
                end
                else
                begin
                    axis_next  = axis_reg + 2'd1;
                    state_next = ami_pkg::ST_NR_MUL;
                end
            end
            ami_pkg::ST_NR_DONE:
            begin
                cmd.op = ami_pkg::DP_NEAR_DONE;
                // A step from within reach of the goal leaves the state untouched.
                if (post_reg || stat.near_now)
                begin
                    state_next = ami_pkg::ST_PUBLISH;
                end
                else
                begin
                    axis_next  = 2'd0;
                    state_next = ami_pkg::ST_ST_MULA;
                end
            end
            ami_pkg::ST_ST_MULA:
            begin
                cmd.op     = ami_pkg::DP_MUL_ACC;
                state_next = ami_pkg::ST_ST_VEL;
            end
            ami_pkg::ST_ST_VEL:
            begin
                cmd.op     = ami_pkg::DP_VEL_UPD;
                state_next = ami_pkg::ST_ST_MULV;
            end
            ami_pkg::ST_ST_MULV:
            begin
                cmd.op     = ami_pkg::DP_MUL_VEL;
                state_next = ami_pkg::ST_ST_POS;
            end
            ami_pkg::ST_ST_POS:
            begin
                cmd.op = ami_pkg::DP_POS_UPD;
                if (axis_reg == AXIS_LAST)
                begin
                    post_next  = 1'b1;
                    state_next = ami_pkg::ST_NR_CLR;
                end
                else
                begin
                    axis_next  = axis_reg + 2'd1;
                    state_next = ami_pkg::ST_ST_MULA;
                end
            end
            ami_pkg::ST_AD_MUL:
            begin
                cmd.op     = ami_pkg::DP_SQ_MUL;
                state_next = ami_pkg::ST_AD_ACC;
            end
            ami_pkg::ST_AD_ACC:
            begin
                cmd.op = ami_pkg::DP_ACCUM;
                if (axis_reg == AXIS_LAST)
                begin
                    state_next = ami_pkg::ST_AD_CHECK;
                end
                else
                begin
                    axis_next  = axis_reg + 2'd1;
                    state_next = ami_pkg::ST_AD_MUL;
                end
            end
            ami_pkg::ST_AD_CHECK:
            begin
                if (stat.cap_now)
                begin
                    cmd.op     = ami_pkg::DP_SQRT_INIT;
                    cnt_next   = 5'd0;
                    state_next = ami_pkg::ST_SQ_ITER;
                end
                else
                begin
                    cmd.op     = ami_pkg::DP_ACC_FROM_S;
                    post_next  = 1'b1;
                    state_next = ami_pkg::ST_NR_CLR;
                end
            end
            ami_pkg::ST_SQ_ITER:
            begin
                cmd.op = ami_pkg::DP_SQRT_ITER;
                if (cnt_reg == SQ_LAST)
                begin
                    axis_next  = 2'd0;
                    state_next = ami_pkg::ST_DV_INIT;
                end
                else
                begin
                    cnt_next = cnt_reg + 5'd1;
                end
            end
            ami_pkg::ST_DV_INIT:
            begin
                cmd.op     = ami_pkg::DP_DIV_INIT;
                cnt_next   = 5'd0;
                state_next = ami_pkg::ST_DV_ITER;
            end
            ami_pkg::ST_DV_ITER:
            begin
                cmd.op = ami_pkg::DP_DIV_ITER;
                if (cnt_reg == DV_LAST)
                begin
                    state_next = ami_pkg::ST_DV_DONE;
                end
                else
                begin
                    cnt_next = cnt_reg + 5'd1;
                end
            end
            ami_pkg::ST_DV_DONE:
            begin
                cmd.op = ami_pkg::DP_DIV_DONE;
                if (axis_reg == AXIS_LAST)
                begin
                    post_next  = 1'b1;
                    state_next = ami_pkg::ST_NR_CLR;
                end
                else
                begin
                    axis_next  = axis_reg + 2'd1;
                    state_next = ami_pkg::ST_DV_INIT;
                end
            end
            ami_pkg::ST_PUBLISH:
            begin
                if (!stat.out_busy)
                begin
                    cmd.op     = ami_pkg::DP_PUBLISH;
                    state_next = ami_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = ami_pkg::ST_IDLE;
            end
        endcase
    end

    // A result is only moved to the output when the output register is free.
    assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.op == ami_pkg::DP_PUBLISH) |-> !stat.out_busy)
        else $error("result published over an untaken result");

    // The iteration counter never runs past the last iteration of the division loop.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ami_pkg::ST_DV_ITER) |-> (cnt_reg <= DV_LAST))
        else $error("division ran past its last iteration");

    // A new transaction is only taken while the sequencer is idle.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_ready |-> (state_reg == ami_pkg::ST_IDLE))
        else $error("input taken outside the idle state");

endmodule

`default_nettype wire

@@ rtl/ami_datapath.sv @@
`default_nettype none

module ami_datapath (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire ami_pkg::dp_cmd_t   cmd,
    output ami_pkg::dp_stat_t       stat,
    input  wire logic               cfg_wr_en,
    input  wire logic [2:0]         cfg_index,
    input  wire logic [31:0]        cfg_wr_data,
    input  wire logic [1:0]         req_type,
    input  wire logic [16:0]        time_delta,
    input  wire logic signed [31:0] vec_in [3],
    output logic signed [31:0]      res_pos [3],
    output logic signed [31:0]      res_vel [3],
    output logic signed [31:0]      res_acc [3],
    output logic                    res_near,
    output logic                    out_valid,
    input  wire logic               out_ready
);

    // Saturate a 33-bit sum to the 32-bit signed range.
    function automatic logic signed [31:0] sat33(input logic signed [32:0] v);
        logic signed [31:0] r;
        if (v[32] != v[31])
        begin
            r = v[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
        end
        else
        begin
            r = v[31:0];
        end
        return r;
    endfunction

    // Round a Q32.32 product to Q16.16 (ties upward) and saturate.
    function automatic logic signed [31:0] rnd_sat(input logic signed [65:0] p);
        logic signed [65:0] t;
        logic signed [65:0] sh;
        logic signed [31:0] r;
        t  = p + 66'sd32768;
        sh = t >>> 16;
        if ((sh[65:31] == '0) || (sh[65:31] == '1))
        begin
            r = sh[31:0];
        end
        else
        begin
            r = sh[65] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
        end
        return r;
    endfunction

    logic signed [31:0] cfg_reg [ami_pkg::CFG_COUNT];

    logic signed [31:0] pos_reg [3], pos_next [3];
    logic signed [31:0] vel_reg [3], vel_next [3];
    logic signed [31:0] acc_reg [3], acc_next [3];
    logic signed [31:0] s_reg [3], s_next [3];
    logic signed [31:0] vin_reg [3], vin_next [3];
    ami_pkg::req_kind_t kind_reg, kind_next;
    logic [16:0]        dt_reg, dt_next;

    logic signed [65:0] prod_reg, prod_next;
    logic [63:0]        accum_reg, accum_next;
    logic               far_reg, far_next;
    logic               near_reg, near_next;

    logic [63:0]        rem_reg, rem_next;
    logic [63:0]        root_reg, root_next;
    logic [63:0]        bit_reg, bit_next;
    logic [31:0]        drem_reg, drem_next;
    logic [18:0]        quo_reg, quo_next;
    logic               neg_reg, neg_next;

    logic signed [31:0] opos_reg [3], opos_next [3];
    logic signed [31:0] ovel_reg [3], ovel_next [3];
    logic signed [31:0] oacc_reg [3], oacc_next [3];
    logic               onear_reg, onear_next;
    logic               oval_reg, oval_next;

    logic [1:0]         ax;
    logic signed [32:0] mul_a, mul_b;
    logic signed [65:0] mult;
    logic signed [31:0] rnd;
    logic signed [31:0] goal;
    logic signed [32:0] goal_diff;
    logic               in_range;
    logic signed [31:0] pos_sum;
    logic signed [31:0] lo, hi;
    logic [63:0]        sq_t;
    logic [31:0]        m;
    logic [31:0]        mag;
    logic [34:0]        mag5;
    logic [51:0]        num;
    logic [32:0]        dv_t;
    logic [32:0]        dv_d;
    logic [31:0]        q_ext;

    assign ax = cmd.axis;
    assign m  = root_reg[31:0];

    // Configuration registers; writes beyond the list fall away.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < ami_pkg::CFG_COUNT; i++)
            begin
                cfg_reg[i] <= 32'sd0;
            end
        end
        else if (cfg_wr_en && (cfg_index < 3'(ami_pkg::CFG_COUNT)))
        begin
            cfg_reg[cfg_index] <= cfg_wr_data;
        end
    end

    // Shared multiplier, its result registered before use.
    assign mult = mul_a * mul_b;
    assign rnd  = rnd_sat(prod_reg);

    // Per-axis helpers for the goal test, clamping and the cap division, and the square root step.
    always_comb
    begin
        goal      = cfg_reg[ami_pkg::CFG_GOAL_X + {1'b0, ax}];
        goal_diff = {pos_reg[ax][31], pos_reg[ax]} - {goal[31], goal};
        in_range  = (goal_diff < 33'sd131072) && (goal_diff > -33'sd131072);
        pos_sum   = sat33({pos_reg[ax][31], pos_reg[ax]} + {rnd[31], rnd});
        lo        = (ax == ami_pkg::AXIS_X) ? cfg_reg[ami_pkg::CFG_BOUND_X_MIN]
                                            : cfg_reg[ami_pkg::CFG_BOUND_Z_MIN];
        hi        = (ax == ami_pkg::AXIS_X) ? cfg_reg[ami_pkg::CFG_BOUND_X_MAX]
                                            : cfg_reg[ami_pkg::CFG_BOUND_Z_MAX];
        sq_t      = root_reg + bit_reg;
        mag       = s_reg[ax][31] ? 32'(-s_reg[ax]) : 32'(s_reg[ax]);
        mag5      = {3'b000, mag} + {1'b0, mag, 2'b00};
        num       = {1'b0, mag5, 16'h0000} + {21'd0, m[31:1]};
        dv_t      = {drem_reg, quo_reg[18]};
        dv_d      = dv_t - {1'b0, m};
        q_ext     = {13'd0, quo_reg};
    end

    // Next-state logic of the datapath registers.
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            pos_next[i]  = pos_reg[i];
            vel_next[i]  = vel_reg[i];
            acc_next[i]  = acc_reg[i];
            s_next[i]    = s_reg[i];
            vin_next[i]  = vin_reg[i];
            opos_next[i] = opos_reg[i];
            ovel_next[i] = ovel_reg[i];
            oacc_next[i] = oacc_reg[i];
        end
        kind_next  = kind_reg;
        dt_next    = dt_reg;
        prod_next  = prod_reg;
        accum_next = accum_reg;
        far_next   = far_reg;
        near_next  = near_reg;
        rem_next   = rem_reg;
        root_next  = root_reg;
        bit_next   = bit_reg;
        drem_next  = drem_reg;
        quo_next   = quo_reg;
        neg_next   = neg_reg;
        onear_next = onear_reg;
        oval_next  = oval_reg && !out_ready;
        mul_a      = 33'sd0;
        mul_b      = 33'sd0;
        case (cmd.op)
            ami_pkg::DP_LOAD:
            begin
                kind_next = ami_pkg::req_kind_t'(req_type);
                dt_next   = time_delta;
                for (int i = 0; i < 3; i++)
                begin
                    vin_next[i] = vec_in[i];
                end
            end
            ami_pkg::DP_NEAR_CLR:
            begin
                accum_next = 64'd0;
                far_next   = 1'b0;
            end
            ami_pkg::DP_NEAR_MUL:
            begin
                mul_a     = in_range ? goal_diff : 33'sd0;
                mul_b     = in_range ? goal_diff : 33'sd0;
                prod_next = mult;
                far_next  = far_reg || !in_range;
            end
            ami_pkg::DP_ACCUM:
            begin
                accum_next = accum_reg + prod_reg[63:0];
            end
            ami_pkg::DP_NEAR_DONE:
            begin
                near_next = stat.near_now;
            end
            ami_pkg::DP_MUL_ACC:
            begin
                mul_a     = {acc_reg[ax][31], acc_reg[ax]};
                mul_b     = {16'd0, dt_reg};
                prod_next = mult;
            end
            ami_pkg::DP_VEL_UPD:
            begin
                vel_next[ax] = sat33({vel_reg[ax][31], vel_reg[ax]} + {rnd[31], rnd});
                acc_next[ax] = rnd;
            end
            ami_pkg::DP_MUL_VEL:
            begin
                mul_a     = {vel_reg[ax][31], vel_reg[ax]};
                mul_b     = {16'd0, dt_reg};
                prod_next = mult;
            end
            ami_pkg::DP_POS_UPD:
            begin
                pos_next[ax] = pos_sum;
                // Only x and z are kept inside the area; minimum is tested first.
                if ((ax == ami_pkg::AXIS_X) || (ax == ami_pkg::AXIS_Z))
                begin
                    if (pos_sum < lo)
                    begin
                        pos_next[ax] = lo;
                        vel_next[ax] = 32'sd0;
                    end
                    else if (pos_sum > hi)
                    begin
                        pos_next[ax] = hi;
                        vel_next[ax] = 32'sd0;
                    end
                end
            end
            ami_pkg::DP_SUM_SAT:
            begin
                for (int i = 0; i < 3; i++)
                begin
                    s_next[i] = sat33({acc_reg[i][31], acc_reg[i]} + {vin_reg[i][31], vin_reg[i]});
                end
                accum_next = 64'd0;
            end
            ami_pkg::DP_SQ_MUL:
            begin
                mul_a     = {s_reg[ax][31], s_reg[ax]};
                mul_b     = {s_reg[ax][31], s_reg[ax]};
                prod_next = mult;
            end
            ami_pkg::DP_ACC_FROM_S:
            begin
                for (int i = 0; i < 3; i++)
                begin
                    acc_next[i] = s_reg[i];
                end
            end
            ami_pkg::DP_SQRT_INIT:
            begin
                rem_next  = accum_reg;
                root_next = 64'd0;
                bit_next  = ami_pkg::SQRT_BIT0;
            end
            ami_pkg::DP_SQRT_ITER:
            begin
                // One result bit per cycle of the integer square root.
                if (rem_reg >= sq_t)
                begin
                    rem_next  = rem_reg - sq_t;
                    root_next = (root_reg >> 1) + bit_reg;
                end
                else
                begin
                    root_next = root_reg >> 1;
                end
                bit_next = bit_reg >> 2;
            end
            ami_pkg::DP_DIV_INIT:
            begin
                // The quotient stays below 2^19, so the upper bits start as the remainder.
                neg_next  = s_reg[ax][31];
                drem_next = num[50:19];
                quo_next  = num[18:0];
            end
            ami_pkg::DP_DIV_ITER:
            begin
                if (!dv_d[32])
                begin
                    drem_next = dv_d[31:0];
                    quo_next  = {quo_reg[17:0], 1'b1};
                end
                else
                begin
                    drem_next = dv_t[31:0];
                    quo_next  = {quo_reg[17:0], 1'b0};
                end
            end
            ami_pkg::DP_DIV_DONE:
            begin
                acc_next[ax] = neg_reg ? -$signed(q_ext) : $signed(q_ext);
            end
            ami_pkg::DP_SET_ACC:
            begin
                for (int i = 0; i < 3; i++)
                begin
                    acc_next[i] = vin_reg[i];
                end
            end
            ami_pkg::DP_SET_POS:
            begin
                for (int i = 0; i < 3; i++)
                begin
                    pos_next[i] = vin_reg[i];
                end
            end
            ami_pkg::DP_PUBLISH:
            begin
                for (int i = 0; i < 3; i++)
                begin
                    opos_next[i] = pos_reg[i];
                    ovel_next[i] = vel_reg[i];
                    oacc_next[i] = acc_reg[i];
                end
                onear_next = near_reg;
                oval_next  = 1'b1;
            end
            default:
            begin
            end
        endcase
    end

    // Agent state and the output transaction valid flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 3; i++)
            begin
                pos_reg[i] <= 32'sd0;
                vel_reg[i] <= 32'sd0;
                acc_reg[i] <= 32'sd0;
            end
            oval_reg <= 1'b0;
        end
        else
        begin
            for (int i = 0; i < 3; i++)
            begin
                pos_reg[i] <= pos_next[i];
                vel_reg[i] <= vel_next[i];
                acc_reg[i] <= acc_next[i];
            end
            oval_reg <= oval_next;
        end
    end

    // Working and output payload registers.
    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 3; i++)
        begin
            s_reg[i]    <= s_next[i];
            vin_reg[i]  <= vin_next[i];
            opos_reg[i] <= opos_next[i];
            ovel_reg[i] <= ovel_next[i];
            oacc_reg[i] <= oacc_next[i];
        end
        kind_reg  <= kind_next;
        dt_reg    <= dt_next;
        prod_reg  <= prod_next;
        accum_reg <= accum_next;
        far_reg   <= far_next;
        near_reg  <= near_next;
        rem_reg   <= rem_next;
        root_reg  <= root_next;
        bit_reg   <= bit_next;
        drem_reg  <= drem_next;
        quo_reg   <= quo_next;
        neg_reg   <= neg_next;
        onear_reg <= onear_next;
    end

    // Status back to the controller.
    always_comb
    begin
        stat.kind     = kind_reg;
        stat.near_now = !far_reg && (accum_reg[63:34] == 30'd0);
        stat.cap_now  = accum_reg >= ami_pkg::ACC_CAP_SQ;
        stat.out_busy = oval_reg && !out_ready;
    end

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            res_pos[i] = opos_reg[i];
            res_vel[i] = ovel_reg[i];
            res_acc[i] = oacc_reg[i];
        end
        res_near  = onear_reg;
        out_valid = oval_reg;
    end

    // The division starts with a remainder below the divisor.
    assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.op == ami_pkg::DP_DIV_INIT) |-> (num[51:19] < {1'b0, m}))
        else $error("cap division would overflow its quotient");

    // A capped component never exceeds 5.0 by more than one unit.
    assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.op == ami_pkg::DP_DIV_DONE) |-> (quo_reg <= 19'd327681))
        else $error("cap quotient out of range");

    // The cap root is only used once it is at least 5.0.
    assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.op == ami_pkg::DP_DIV_INIT) |-> (m >= 32'd327680))
        else $error("cap root below 5.0");

endmodule

`default_nettype wire

@@ rtl/agent_motion_integrator_top.sv @@
// A step first tests for the goal; from outside its reach it then updates each axis in
// turn and tests again, from within reach it leaves the state as it is. Set and place
// load the vector and then run the goal test; an add saturates the sum, squares it and,
// if capped, takes a square root and a division per axis before the goal test.
// One item is processed at a time; the next is accepted while a result waits. Reset
// clears the agent state, the configuration and the output valid flag to zero.
`default_nettype none

module agent_motion_integrator_top (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               cfg_wr_en,
    input  wire logic [2:0]         cfg_index,
    input  wire logic [31:0]        cfg_wr_data,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire logic [1:0]         req_type,
    input  wire logic [16:0]        time_delta,
    input  wire logic signed [31:0] vec_x,
    input  wire logic signed [31:0] vec_y,
    input  wire logic signed [31:0] vec_z,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output logic signed [31:0]      pos_x,
    output logic signed [31:0]      pos_y,
    output logic signed [31:0]      pos_z,
    output logic signed [31:0]      vel_x,
    output logic signed [31:0]      vel_y,
    output logic signed [31:0]      vel_z,
    output logic signed [31:0]      acc_x,
    output logic signed [31:0]      acc_y,
    output logic signed [31:0]      acc_z,
    output logic                    near_goal
);

    ami_pkg::dp_cmd_t  cmd;
    ami_pkg::dp_stat_t stat;
    logic signed [31:0] vec_in [3];
    logic signed [31:0] res_pos [3];
    logic signed [31:0] res_vel [3];
    logic signed [31:0] res_acc [3];

    assign vec_in[0] = vec_x;
    assign vec_in[1] = vec_y;
    assign vec_in[2] = vec_z;

    // Sequencer.
    ami_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    // Arithmetic and state.
    ami_datapath u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .stat        (stat),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_wr_data (cfg_wr_data),
        .req_type    (req_type),
        .time_delta  (time_delta),
        .vec_in      (vec_in),
        .res_pos     (res_pos),
        .res_vel     (res_vel),
        .res_acc     (res_acc),
        .res_near    (near_goal),
        .out_valid   (out_valid),
        .out_ready   (out_ready)
    );

    assign pos_x = res_pos[0];
    assign pos_y = res_pos[1];
    assign pos_z = res_pos[2];
    assign vel_x = res_vel[0];
    assign vel_y = res_vel[1];
    assign vel_z = res_vel[2];
    assign acc_x = res_acc[0];
    assign acc_y = res_acc[1];
    assign acc_z = res_acc[2];

endmodule

`default_nettype wire
